// ===== hw/rtl/bws_pkg.sv =====
// Shared types and constants for the 2D box window sum block.
`timescale 1ns / 1ps
`default_nettype none

package bws_pkg;

  // Field widths fixed by the stream format.
  localparam int SAMPLE_BITS = 16;
  localparam int COL_BITS    = 20;
  localparam int SUM_BITS    = 24;
  localparam int POS_BITS    = 10;

  // Configuration port.
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int WIN_CFG_W   = 5;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_ROWS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COLS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE = 2'd2;

  // One input transfer.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          start_of_frame;
  } in_item_t;

  // One result transfer.
  typedef struct packed {
    logic signed [SUM_BITS-1:0] window_sum;
    logic [POS_BITS-1:0]        out_row;
    logic [POS_BITS-1:0]        out_col;
    logic                       end_of_frame;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/box_window_sum_2d_top.sv =====
// Top level of the 2D box window sum: raster tracking, column sums and window chain.
//
// Usage:
//   Samples enter on the in_ channel (in_valid, in_stall, in_data) in raster
//   order; start_of_frame forces the sample to row 0, column 0. For every
//   sample that closes a full window (the sample is its bottom-right corner),
//   one result leaves on the out_ channel (out_valid, out_stall, out_data)
//   with the window sum, the window's top-left row and column, and
//   end_of_frame on the last sum of the frame.
//   Frame size and window side are written on the cfg_ port while idle.
//   Throughput is one sample per cycle while in_stall is low. A result is
//   formed on its way to the output register: the line store and column
//   sum reads are launched at the transfer edge, stage 1 updates the column
//   sum, and stage 2 forms the horizontal sum over the chain of recent
//   column sums.
//   After reset the column sum memory is cleared, one entry a cycle, over
//   all MAX_WIDTH entries; in_stall stays high during that sweep.
//   When a result waits in the output register and out_stall is high, the
//   whole pipeline holds and in_stall is raised in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module box_window_sum_2d_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WINDOW = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire bws_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output bws_pkg::out_item_t                      out_data,
  input  wire logic                               cfg_wr_en,
  input  wire logic [bws_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [bws_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SB  = bws_pkg::SAMPLE_BITS;
  localparam int CSB = bws_pkg::COL_BITS;
  localparam int SMB = bws_pkg::SUM_BITS;
  localparam int PB  = bws_pkg::POS_BITS;

  localparam int RB  = $clog2(MAX_HEIGHT + 1);
  localparam int CB  = $clog2(MAX_WIDTH + 1);
  localparam int WB  = $clog2(MAX_WINDOW + 1);
  localparam int SW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CIW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int MW1 = (RB > CB) ? RB : CB;
  localparam int MW2 = (MW1 > WB) ? MW1 : WB;
  localparam int XW  = MW2 + 1;

  localparam int LS_DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int LS_AW    = (LS_DEPTH > 1) ? $clog2(LS_DEPTH) : 1;

  localparam int RST_ROWS = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;
  localparam int RST_COLS = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam int RST_WIN  = (3 > MAX_WINDOW) ? MAX_WINDOW : 3;

  // Configuration, held already clamped to the legal ranges.
  logic [RB-1:0] rows_r;
  logic [CB-1:0] cols_r;
  logic [WB-1:0] win_r;
  logic [RB-1:0] rows_wr;
  logic [CB-1:0] cols_wr;
  logic [WB-1:0] win_wr;
  logic [bws_pkg::WIN_CFG_W-1:0] win_field;

  // Raster position.
  logic [RB-1:0] row_pos_r, row_pos_nxt;
  logic [CB-1:0] col_pos_r, col_pos_nxt;
  logic [SW-1:0] slot_r, slot_nxt;

  // Handshake and clearing sweep.
  logic           en;
  logic           accept;
  logic           clr_active_r;
  logic [CIW-1:0] clr_addr_r;

  // Entry stage signals.
  logic          restart;
  logic [XW-1:0] r_x, c_x, w_x, rows_x, cols_x, slot_x, old_slot_x;
  logic [SW-1:0] slot0;
  logic          last_col, last_row;
  logic          emit0, eof0;
  logic [LS_AW-1:0] ls_rd_addr, ls_wr_addr;
  logic          fwd_cs_nxt, fwd_ls_nxt;

  // Stage 1 registers.
  logic                  s1_valid_r;
  logic signed [SB-1:0]  s1_sample_r;
  logic [CB-1:0]         s1_c_r;
  logic [SW-1:0]         s1_slot_r;
  logic                  s1_use_col_r, s1_use_old_r, s1_first_col_r, s1_sub_col_r;
  logic                  s1_emit_r, s1_eof_r;
  logic [PB-1:0]         s1_row_r, s1_col_r;
  logic                  fwd_cs_r, fwd_ls_r;
  logic [SB-1:0]         fwd_ls_data_r;

  // Stage 1 memory data and column sum update.
  logic [CSB-1:0] cs_rd;
  logic [SB-1:0]  ls_rd;
  logic [CSB-1:0] col_prev, cs_nxt;
  logic [SB-1:0]  old_s;
  logic           cs_wr_en;
  logic [CIW-1:0] cs_wr_addr;
  logic [CSB-1:0] cs_wr_data;
  logic           ls_wr_en;

  // Stage 2 registers.
  logic            s2_valid_r;
  logic [CSB-1:0]  s2_cs_r;
  logic            s2_first_col_r, s2_sub_col_r, s2_emit_r, s2_eof_r;
  logic [PB-1:0]   s2_row_r, s2_col_r;

  // Horizontal sum over the chain.
  logic [CSB-1:0] chain_q [MAX_WINDOW];
  logic [SW-1:0]  tap_idx;
  logic [CSB-1:0] tap;
  logic           chain_shift;
  logic [SMB-1:0] run_r, run_nxt;

  // Output register.
  logic               out_valid_r;
  bws_pkg::out_item_t out_data_r;

  // Clamp written values into the legal ranges.
  assign win_field = cfg_data[bws_pkg::WIN_CFG_W-1:0];

  always_comb begin
    if (cfg_data == '0) begin
      rows_wr = RB'(1);
      cols_wr = CB'(1);
    end else begin
      rows_wr = (32'(cfg_data) > 32'(MAX_HEIGHT)) ? RB'(MAX_HEIGHT) : RB'(cfg_data);
      cols_wr = (32'(cfg_data) > 32'(MAX_WIDTH)) ? CB'(MAX_WIDTH) : CB'(cfg_data);
    end
    if (win_field == '0) begin
      win_wr = WB'(1);
    end else begin
      win_wr = (32'(win_field) > 32'(MAX_WINDOW)) ? WB'(MAX_WINDOW) : WB'(win_field);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= RB'(RST_ROWS);
      cols_r <= CB'(RST_COLS);
      win_r  <= WB'(RST_WIN);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bws_pkg::CFG_FRAME_ROWS:  rows_r <= rows_wr;
        bws_pkg::CFG_FRAME_COLS:  cols_r <= cols_wr;
        bws_pkg::CFG_WINDOW_SIZE: win_r  <= win_wr;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless a result waits on a stalled receiver.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en || clr_active_r;
  assign accept   = in_valid && !in_stall;

  // Entry stage: resolve the raster position of the incoming sample.
  always_comb begin
    rows_x  = XW'(rows_r);
    cols_x  = XW'(cols_r);
    w_x     = XW'(win_r);
    restart = in_data.start_of_frame || (XW'(row_pos_r) >= rows_x) ||
              (XW'(col_pos_r) >= cols_x);
    r_x     = restart ? '0 : XW'(row_pos_r);
    c_x     = restart ? '0 : XW'(col_pos_r);
    slot0   = restart ? '0 : slot_r;
    slot_x  = XW'(slot0);

    last_col = (c_x + XW'(1)) >= cols_x;
    last_row = (r_x + XW'(1)) >= rows_x;
    emit0    = ((r_x + XW'(1)) >= w_x) && ((c_x + XW'(1)) >= w_x);
    eof0     = (r_x == rows_x - XW'(1)) && (c_x == cols_x - XW'(1));

    // Line store row that holds the sample leaving the window.
    old_slot_x = (slot_x >= w_x) ? (slot_x - w_x) : (slot_x + XW'(MAX_WINDOW) - w_x);
    ls_rd_addr = LS_AW'(32'(old_slot_x) * 32'(MAX_WIDTH) + 32'(c_x));
    ls_wr_addr = LS_AW'(32'(s1_slot_r) * 32'(MAX_WIDTH) + 32'(s1_c_r));

    // A write still in flight in stage 1 is forwarded to the new read.
    fwd_cs_nxt = s1_valid_r && (s1_c_r == CB'(c_x));
    fwd_ls_nxt = s1_valid_r && (ls_wr_addr == ls_rd_addr);

    // Next raster position.
    if (last_col) begin
      col_pos_nxt = '0;
      if (last_row) begin
        row_pos_nxt = '0;
        slot_nxt    = '0;
      end else begin
        row_pos_nxt = RB'(r_x + XW'(1));
        slot_nxt    = (slot0 == SW'(MAX_WINDOW - 1)) ? '0 : slot0 + SW'(1);
      end
    end else begin
      col_pos_nxt = CB'(c_x + XW'(1));
      row_pos_nxt = RB'(r_x);
      slot_nxt    = slot0;
    end
  end

  // Position, valid bits and the clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r    <= '0;
      col_pos_r    <= '0;
      slot_r       <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      fwd_cs_r     <= 1'b0;
      fwd_ls_r     <= 1'b0;
      run_r        <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      if (clr_active_r) begin
        if (clr_addr_r == CIW'(MAX_WIDTH - 1)) begin
          clr_active_r <= 1'b0;
        end
        clr_addr_r <= clr_addr_r + CIW'(1);
      end
      if (accept) begin
        row_pos_r <= row_pos_nxt;
        col_pos_r <= col_pos_nxt;
        slot_r    <= slot_nxt;
      end
      if (en) begin
        s1_valid_r  <= accept;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r && s2_emit_r;
        fwd_cs_r    <= fwd_cs_nxt;
        fwd_ls_r    <= fwd_ls_nxt;
        if (s2_valid_r) begin
          run_r <= run_nxt;
        end
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_sample_r    <= in_data.sample;
      s1_c_r         <= CB'(c_x);
      s1_slot_r      <= slot0;
      s1_use_col_r   <= (r_x != '0);
      s1_use_old_r   <= (r_x >= w_x);
      s1_first_col_r <= (c_x == '0);
      s1_sub_col_r   <= (c_x >= w_x);
      s1_emit_r      <= emit0;
      s1_eof_r       <= eof0;
      s1_row_r       <= PB'(r_x + XW'(1) - w_x);
      s1_col_r       <= PB'(c_x + XW'(1) - w_x);
      fwd_ls_data_r  <= s1_sample_r;

      s2_cs_r        <= cs_nxt;
      s2_first_col_r <= s1_first_col_r;
      s2_sub_col_r   <= s1_sub_col_r;
      s2_emit_r      <= s1_emit_r;
      s2_eof_r       <= s1_eof_r;
      s2_row_r       <= s1_row_r;
      s2_col_r       <= s1_col_r;

      out_data_r.window_sum   <= run_nxt;
      out_data_r.out_row      <= s2_row_r;
      out_data_r.out_col      <= s2_col_r;
      out_data_r.end_of_frame <= s2_eof_r;
    end
  end

  // Stage 1: vertical sum of the column, adding the new sample and
  // dropping the one that left the window.
  always_comb begin
    col_prev = fwd_cs_r ? s2_cs_r : cs_rd;
    old_s    = fwd_ls_r ? fwd_ls_data_r : ls_rd;
    cs_nxt   = (s1_use_col_r ? col_prev : '0)
             + {{(CSB - SB){s1_sample_r[SB-1]}}, s1_sample_r}
             - (s1_use_old_r ? {{(CSB - SB){old_s[SB-1]}}, old_s} : '0);
  end

  // Column sum memory writes come from the clearing sweep or from stage 1.
  assign cs_wr_en   = clr_active_r || (en && s1_valid_r);
  assign cs_wr_addr = clr_active_r ? clr_addr_r : s1_c_r[CIW-1:0];
  assign cs_wr_data = clr_active_r ? '0 : cs_nxt;
  assign ls_wr_en   = en && s1_valid_r;

  bws_ram #(
    .WIDTH (CSB),
    .DEPTH (MAX_WIDTH)
  ) u_col_sums (
    .clk     (clk),
    .wr_en   (cs_wr_en),
    .wr_addr (cs_wr_addr),
    .wr_data (cs_wr_data),
    .rd_en   (en),
    .rd_addr (c_x[CIW-1:0]),
    .rd_data (cs_rd)
  );

  bws_ram #(
    .WIDTH (SB),
    .DEPTH (LS_DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ls_wr_en),
    .wr_addr (ls_wr_addr),
    .wr_data (s1_sample_r),
    .rd_en   (en),
    .rd_addr (ls_rd_addr),
    .rd_data (ls_rd)
  );

  // Chain of recent column sums; cell k holds the sum from k+1 samples ago.
  assign chain_shift = en && s2_valid_r;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_chain
    if (k == 0) begin : g_head
      bws_cell u_cell (
        .clk      (clk),
        .shift_en (chain_shift),
        .d_in     (s2_cs_r),
        .d_out    (chain_q[k])
      );
    end else begin : g_body
      bws_cell u_cell (
        .clk      (clk),
        .shift_en (chain_shift),
        .d_in     (chain_q[k-1]),
        .d_out    (chain_q[k])
      );
    end
  end

  // Stage 2: horizontal running sum over the last window columns.
  assign tap_idx = SW'(win_r - WB'(1));
  assign tap     = chain_q[tap_idx];

  always_comb begin
    run_nxt = (s2_first_col_r ? '0 : run_r)
            + {{(SMB - CSB){s2_cs_r[CSB-1]}}, s2_cs_r}
            - (s2_sub_col_r ? {{(SMB - CSB){tap[CSB-1]}}, tap} : '0);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bws_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; returns old data on a same-address write.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bws_cell.sv =====
// One cell of the column-sum delay chain: holds a column sum and passes it on.
`timescale 1ns / 1ps
`default_nettype none

module bws_cell (
  input  wire logic                         clk,
  input  wire logic                         shift_en,
  input  wire logic [bws_pkg::COL_BITS-1:0] d_in,
  output logic      [bws_pkg::COL_BITS-1:0] d_out
);

  logic [bws_pkg::COL_BITS-1:0] value_r;

  // Take the neighbor's value whenever the chain moves.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      value_r <= d_in;
    end
  end

  assign d_out = value_r;

endmodule

`default_nettype wire
